// ----- sv/encoder_edge_velocity_estimator_core_assert.svh -----
// Assertion helpers shared by the estimator RTL
`ifndef ENCODER_EDGE_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH
`define ENCODER_EDGE_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication
`define EEVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EEVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/eevc_pkg.sv -----
package eevc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int UM_W       = 20;
	localparam int TIME_W     = 32;
	localparam int VEL_W      = 16;
	localparam int DIR_W      = 2;
	localparam int QUO_W      = 16;
	localparam int CNT_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UM_PER_TICK     = 2'd1;

	localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 20'd100000;
	localparam logic [UM_W-1:0]       UM_RST       = 20'd1000;

	localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
	localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

	localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7fff;
	localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_SCALE,
		ST_CHK,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic sample_fire;
		logic first;
		logic due;
		logic ovf;
		logic last_step;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic in_ready;
		logic eval;
		logic mul;
		logic scale;
		logic chk;
		logic div;
		logic fin;
		logic out_ld;
	} ctl_t;

endpackage

// ----- sv/eevc_sample_if.sv -----
interface eevc_sample_if import eevc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              level_a;
	logic              level_b;
	logic [TIME_W-1:0] time_now_us;

	modport source (output valid, level_a, level_b, time_now_us, input ready);
	modport sink   (input valid, level_a, level_b, time_now_us, output ready);
endinterface

// ----- sv/eevc_result_if.sv -----
interface eevc_result_if import eevc_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] velocity_mm_s;
	logic                    velocity_updated;
	logic signed [DIR_W-1:0] direction;

	modport source (output valid, velocity_mm_s, velocity_updated, direction, input ready);
	modport sink   (input valid, velocity_mm_s, velocity_updated, direction, output ready);
endinterface

// ----- sv/eevc_cfg_if.sv -----
interface eevc_cfg_if import eevc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink   (input valid, idx, data, output ready);
endinterface

// ----- sv/eevc_cmp_sub.sv -----
module eevc_cmp_sub import eevc_pkg::*; (
	input  logic [TIME_W:0]   a,
	input  logic [TIME_W-1:0] b,
	output logic              ge,
	output logic [TIME_W-1:0] diff
);

	logic [TIME_W+1:0] d;

	// one extra bit catches the borrow
	assign d    = {1'b0, a} - {2'b00, b};
	assign ge   = ~d[TIME_W+1];
	assign diff = d[TIME_W-1:0];

endmodule

// ----- sv/eevc_seq.sv -----
module eevc_seq import eevc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  stat_t  st,
	output ctl_t   ctl,
	output state_t state_q
);

	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (st.sample_fire) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!st.first && st.due) state_d = ST_MUL;
				else                     state_d = ST_DONE;
			end
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_CHK;
			ST_CHK: begin
				if (st.ovf) state_d = ST_FIN;
				else        state_d = ST_DIV;
			end
			ST_DIV: begin
				if (st.last_step) state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_DONE;
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE:  ctl.in_ready = 1'b1;
			ST_EVAL:  ctl.eval     = 1'b1;
			ST_MUL:   ctl.mul      = 1'b1;
			ST_SCALE: ctl.scale    = 1'b1;
			ST_CHK:   ctl.chk      = 1'b1;
			ST_DIV:   ctl.div      = 1'b1;
			ST_FIN:   ctl.fin      = 1'b1;
			ST_DONE:  ctl.out_ld   = st.out_free;
			default:  ctl = '0;
		endcase
	end

endmodule

// ----- sv/encoder_edge_velocity_estimator_core.sv -----
// Non-update sample: evaluation, then the result beat is loaded once the output is free.
// Update sample: multiply and x1000 scale steps, range check, 16 restoring divide steps on
// the shared compare/subtract unit, saturation, load; the divide steps are skipped when
// the range check already saturates.
// One sample in flight; the next is taken from the cycle after the load.
// arst_n low clears FSM and estimator state; defaults: interval 100000 us, 1000 um per tick.
module encoder_edge_velocity_estimator_core import eevc_pkg::*; #(
	parameter int TICK_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	eevc_cfg_if.sink       cfg,
	eevc_sample_if.sink    sample,
	eevc_result_if.source  result
);

`include "encoder_edge_velocity_estimator_core_assert.svh"

	localparam int PW = TICK_BITS + UM_W;
	localparam int NW = PW + 10;
	localparam int HX = (NW - QUO_W > TIME_W) ? NW - QUO_W : TIME_W + 1;

	// configuration
	logic [CFG_DATA_W-1:0] intv_q;
	logic [UM_W-1:0]       um_q;

	// persistent estimator state
	logic                    prev_a_q;
	logic                    started_q;
	logic [TIME_W-1:0]       last_q;
	logic signed [DIR_W-1:0] dir_q;
	logic [TICK_BITS-1:0]    tick_q;
	logic signed [VEL_W-1:0] vel_q;
	logic                    upd_q;

	// sample capture and working registers
	logic              a_q, b_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] dt_q;
	logic [PW-1:0]     prod_q;
	logic [NW-1:0]     num_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [TIME_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic              out_valid_q;

	stat_t  st;
	ctl_t   ctl;
	state_t state_q;

	logic                 edge_a;
	logic [TICK_BITS-1:0] tick_new;
	logic [TIME_W-1:0]    dt;
	logic [HX-1:0]        hi_x;
	logic [TIME_W:0]      su_a;
	logic                 su_ge;
	logic [TIME_W-1:0]    su_diff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intv_q <= INTERVAL_RST;
			um_q   <= UM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_UPDATE_INTERVAL: intv_q <= cfg.data;
				REG_UM_PER_TICK:     um_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign edge_a   = a_q & ~prev_a_q;
	assign tick_new = (edge_a && tick_q != '1) ? tick_q + 1'b1 : tick_q;
	assign dt       = now_q - last_q;
	assign hi_x     = HX'(num_q >> QUO_W);

	// shared unit: range check against dt, then one quotient bit per step
	assign su_a = ctl.div ? {rem_q, low_q[QUO_W-1]} : {1'b0, hi_x[TIME_W-1:0]};

	eevc_cmp_sub u_sub (
		.a    (su_a),
		.b    (dt_q),
		.ge   (su_ge),
		.diff (su_diff)
	);

	assign st.sample_fire = sample.valid & sample.ready;
	assign st.first       = ~started_q;
	assign st.due         = dt > TIME_W'(intv_q);
	assign st.ovf         = (|hi_x[HX-1:TIME_W]) | su_ge;
	assign st.last_step   = cnt_q == CNT_W'(QUO_W - 1);
	assign st.out_free    = ~out_valid_q | result.ready;

	eevc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.st      (st),
		.ctl     (ctl),
		.state_q (state_q)
	);

	assign sample.ready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q  <= 1'b0;
			started_q <= 1'b0;
			last_q    <= '0;
			dir_q     <= DIR_NONE;
			tick_q    <= '0;
			vel_q     <= '0;
		end else begin
			if (ctl.eval) begin
				prev_a_q <= a_q;
				tick_q   <= tick_new;
				if (edge_a) dir_q <= b_q ? DIR_FWD : DIR_REV;
				if (!started_q) begin
					started_q <= 1'b1;
					last_q    <= now_q;
				end else if (st.due) begin
					last_q <= now_q;
				end
			end
			if (ctl.mul) tick_q <= '0;
			if (ctl.fin) begin
				if (dir_q == DIR_FWD) begin
					vel_q <= (ovf_q || quo_q[QUO_W-1]) ? VEL_MAX : $signed(quo_q);
				end else if (dir_q == DIR_REV) begin
					vel_q <= (ovf_q || quo_q > 16'd32768) ? VEL_MIN
						: VEL_W'(-$signed({1'b0, quo_q}));
				end else begin
					vel_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st.sample_fire) begin
			a_q   <= sample.level_a;
			b_q   <= sample.level_b;
			now_q <= sample.time_now_us;
		end
		if (ctl.eval) begin
			dt_q  <= dt;
			upd_q <= 1'b0;
		end
		if (ctl.mul)   prod_q <= PW'(tick_q) * PW'(um_q);
		// x1000 = x1024 - x16 - x8
		if (ctl.scale) begin
			num_q <= (NW'(prod_q) << 10) - (NW'(prod_q) << 4) - (NW'(prod_q) << 3);
		end
		if (ctl.chk) begin
			ovf_q <= st.ovf;
			rem_q <= hi_x[TIME_W-1:0];
			low_q <= num_q[QUO_W-1:0];
			cnt_q <= '0;
		end
		if (ctl.div) begin
			rem_q <= su_ge ? su_diff : su_a[TIME_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], su_ge};
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.fin) upd_q <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			result.velocity_mm_s    <= vel_q;
			result.velocity_updated <= upd_q;
			result.direction        <= dir_q;
		end
	end

	assign result.valid = out_valid_q;

	`EEVC_ASSERT_NXT(a_fire_eval, clk, arst_n, st.sample_fire, state_q == ST_EVAL,
		"accepted sample did not move to evaluation")
	`EEVC_ASSERT_IMP(a_rem_bound, clk, arst_n, state_q == ST_DIV, rem_q < dt_q,
		"divider remainder not below divisor")
	`EEVC_ASSERT_IMP(a_rise_from_done, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_DONE, "result beat raised outside load state")
	`EEVC_ASSERT_IMP(a_dir_code, clk, arst_n, result.valid, result.direction != 2'sb10,
		"invalid direction code on result")

endmodule
